>>> design/stereo_atan_waveshaper_core_macros.svh
// assertion macros shared by the waveshaper rtl
`ifndef STEREO_ATAN_WAVESHAPER_CORE_MACROS_SVH
`define STEREO_ATAN_WAVESHAPER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SAW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("saw assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SAW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("saw assertion failed");

`else

`define SAW_ASSERT_NOW(lbl, ante, cons)
`define SAW_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> design/saw_pkg.sv
// types, constants and the atan angle table of the waveshaper
`timescale 1ns / 1ps
`default_nettype none

package saw_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int ATAN_STAGES   = 16;
  localparam int ANGLE_TAB_LEN = 24;
  localparam int NUM_STAGES    = (ATAN_STAGES < ANGLE_TAB_LEN) ? ATAN_STAGES : ANGLE_TAB_LEN;

  localparam int FRAC_W    = 16;
  localparam int Q15_SH    = 15;
  localparam int Q15_ONE   = 32768;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;

  // 1 + 10*drive tops out at 360448
  localparam int GAIN_W = 19;
  // signed sample times zero-extended gain
  localparam int ARG_W  = SAMPLE_W + GAIN_W + 1;
  // cordic x/y with room for the cordic growth
  localparam int CW     = ARG_W + 2;
  localparam int CX_INIT_SH = SAMPLE_W - 1 + 15;
  // angle units: 2^30 is pi/2
  localparam int ANG_W     = 30;
  localparam int ANG_IDX_W = 5;
  localparam int ZW        = 33;
  // shaped per-channel value in q.30 with headroom
  localparam int SW        = 35;
  localparam int ACC_W     = SW + 20;
  localparam int DRY_SH    = 31 - SAMPLE_W;
  localparam int ROUND_SH  = 46 - SAMPLE_W;
  localparam int MIX_STAGES = 8;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (ROUND_SH - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO     = ACC_W'(-(1 << (SAMPLE_W - 1)));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE = 3'd0,
    REG_WET   = 3'd1,
    REG_WIDTH = 3'd2,
    REG_SYM   = 3'd3,
    REG_BIAS  = 3'd4,
    REG_DC    = 3'd5
  } reg_idx_e;

  // derived register values, all fractions already clamped to 1.0
  typedef struct packed {
    logic [GAIN_W-1:0]        gain;
    logic [FRAC_W:0]          sym_pos;
    logic [FRAC_W-1:0]        sym_neg;
    logic signed [FRAC_W:0]   bias_dc;
    logic [FRAC_W-1:0]        width;
    logic [FRAC_W-1:0]        wet;
    logic [FRAC_W-1:0]        dry;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain:    GAIN_W'(196608),
    sym_pos: 17'd49152,
    sym_neg: 16'd16384,
    bias_dc: 17'sd0,
    width:   16'd16384,
    wet:     16'd16384,
    dry:     16'd16384
  };

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } lane_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry_l;
    logic signed [SAMPLE_W-1:0] dry_r;
    logic                       last;
  } side_t;

  function automatic logic [ANG_W-1:0] angle_of(input logic [ANG_IDX_W-1:0] k);
    case (k)
      5'd0:    angle_of = 30'd536870912;
      5'd1:    angle_of = 30'd316933406;
      5'd2:    angle_of = 30'd167458907;
      5'd3:    angle_of = 30'd85004756;
      5'd4:    angle_of = 30'd42667331;
      5'd5:    angle_of = 30'd21354465;
      5'd6:    angle_of = 30'd10679838;
      5'd7:    angle_of = 30'd5340245;
      5'd8:    angle_of = 30'd2670163;
      5'd9:    angle_of = 30'd1335087;
      5'd10:   angle_of = 30'd667544;
      5'd11:   angle_of = 30'd333772;
      5'd12:   angle_of = 30'd166886;
      5'd13:   angle_of = 30'd83443;
      5'd14:   angle_of = 30'd41722;
      5'd15:   angle_of = 30'd20861;
      5'd16:   angle_of = 30'd10430;
      5'd17:   angle_of = 30'd5215;
      5'd18:   angle_of = 30'd2608;
      5'd19:   angle_of = 30'd1304;
      5'd20:   angle_of = 30'd652;
      5'd21:   angle_of = 30'd326;
      5'd22:   angle_of = 30'd163;
      5'd23:   angle_of = 30'd81;
      default: angle_of = 30'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> design/saw_stream_if.sv
// valid/ready stream interfaces for input and output frames
`timescale 1ns / 1ps
`default_nettype none

interface saw_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [saw_pkg::SAMPLE_W-1:0] left_in;
  logic signed [saw_pkg::SAMPLE_W-1:0] right_in;
  logic                                frame_last;

  modport source (output valid, output left_in, output right_in, output frame_last,
                  input ready);
  modport sink (input valid, input left_in, input right_in, input frame_last,
                output ready);
endinterface

interface saw_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [saw_pkg::SAMPLE_W-1:0] left_out;
  logic signed [saw_pkg::SAMPLE_W-1:0] right_out;
  logic                                frame_last_out;

  modport source (output valid, output left_out, output right_out, output frame_last_out,
                  input ready);
  modport sink (input valid, input left_out, input right_out, input frame_last_out,
                output ready);
endinterface

`default_nettype wire

>>> design/saw_cfg_regs.sv
// configuration registers with clamping and derived gain values
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_atan_waveshaper_core_macros.svh"

module saw_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [saw_pkg::CFG_IDX_W-1:0]    idx_i,
  input  logic [saw_pkg::FRAC_W-1:0]       wdata_i,
  output saw_pkg::cfg_t                    cfg_o
);

  saw_pkg::cfg_t                     cfg_q, cfg_d;
  logic signed [saw_pkg::FRAC_W-1:0] bias_q, bias_d;
  logic signed [saw_pkg::FRAC_W-1:0] dc_q, dc_d;
  logic [saw_pkg::FRAC_W-1:0]        frac;
  logic [saw_pkg::GAIN_W-1:0]        frac_x10;

  // fractions above one count as one
  assign frac = (wdata_i > saw_pkg::FRAC_W'(saw_pkg::Q15_ONE)) ?
                saw_pkg::FRAC_W'(saw_pkg::Q15_ONE) : wdata_i;
  assign frac_x10 = (saw_pkg::GAIN_W'(frac) << 3) + (saw_pkg::GAIN_W'(frac) << 1);

  always_comb begin
    cfg_d  = cfg_q;
    bias_d = bias_q;
    dc_d   = dc_q;
    if (we_i) begin
      case (saw_pkg::reg_idx_e'(idx_i))
        saw_pkg::REG_DRIVE: begin
          cfg_d.gain = saw_pkg::GAIN_W'(saw_pkg::Q15_ONE) + frac_x10;
        end
        saw_pkg::REG_WET: begin
          cfg_d.wet = frac;
          cfg_d.dry = saw_pkg::FRAC_W'(saw_pkg::Q15_ONE) - frac;
        end
        saw_pkg::REG_WIDTH: begin
          cfg_d.width = frac;
        end
        saw_pkg::REG_SYM: begin
          cfg_d.sym_pos = 17'(saw_pkg::Q15_ONE) + 17'(frac);
          cfg_d.sym_neg = saw_pkg::FRAC_W'(saw_pkg::Q15_ONE) - frac;
        end
        saw_pkg::REG_BIAS: begin
          bias_d        = $signed(wdata_i);
          cfg_d.bias_dc = 17'($signed(wdata_i)) - 17'(dc_q);
        end
        saw_pkg::REG_DC: begin
          dc_d          = $signed(wdata_i);
          cfg_d.bias_dc = 17'(bias_q) - 17'($signed(wdata_i));
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= saw_pkg::CFG_RESET;
      bias_q <= '0;
      dc_q   <= '0;
    end else begin
      cfg_q  <= cfg_d;
      bias_q <= bias_d;
      dc_q   <= dc_d;
    end
  end

  assign cfg_o = cfg_q;

  `SAW_ASSERT_NEXT(a_bad_index_ignored, we_i && (idx_i >= saw_pkg::CFG_IDX_W'(saw_pkg::NUM_REGS)), $stable(cfg_q))
  `SAW_ASSERT_NOW(a_mix_shares_sum_to_one, 1'b1, (17'(cfg_q.wet) + 17'(cfg_q.dry)) == 17'(saw_pkg::Q15_ONE))

endmodule

`default_nettype wire

>>> design/saw_front.sv
// drive multiply and cordic start values for both channels
`timescale 1ns / 1ps
`default_nettype none

module saw_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [saw_pkg::SAMPLE_W-1:0] left_i,
  input  logic signed [saw_pkg::SAMPLE_W-1:0] right_i,
  input  logic                                last_i,
  input  logic [saw_pkg::GAIN_W-1:0]          gain_i,
  output logic                                valid_o,
  output saw_pkg::lane_t                      lane_l_o,
  output saw_pkg::lane_t                      lane_r_o,
  output saw_pkg::side_t                      side_o
);

  logic                             va_q, vb_q;
  logic signed [saw_pkg::ARG_W-1:0] arg_l_q, arg_r_q;
  saw_pkg::side_t                   side_a_q, side_b_q;
  saw_pkg::lane_t                   lane_l_q, lane_r_q;
  logic signed [saw_pkg::GAIN_W:0]  gain_s;

  function automatic saw_pkg::lane_t lane_init(input logic signed [saw_pkg::ARG_W-1:0] arg);
    logic signed [saw_pkg::CW-1:0] ext;
    saw_pkg::lane_t                ln;
    ext    = saw_pkg::CW'(arg);
    ln.cx  = saw_pkg::CW'(1) <<< saw_pkg::CX_INIT_SH;
    ln.cy  = arg[saw_pkg::ARG_W-1] ? -ext : ext;
    ln.z   = '0;
    ln.neg = arg[saw_pkg::ARG_W-1];
    return ln;
  endfunction

  assign gain_s = $signed({1'b0, gain_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      arg_l_q  <= left_i * gain_s;
      arg_r_q  <= right_i * gain_s;
      side_a_q <= '{dry_l: left_i, dry_r: right_i, last: last_i};
      lane_l_q <= lane_init(arg_l_q);
      lane_r_q <= lane_init(arg_r_q);
      side_b_q <= side_a_q;
    end
  end

  assign valid_o  = vb_q;
  assign lane_l_o = lane_l_q;
  assign lane_r_o = lane_r_q;
  assign side_o   = side_b_q;

endmodule

`default_nettype wire

>>> design/saw_cordic_cell.sv
// one vectoring cordic iteration for the left and right lanes
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_atan_waveshaper_core_macros.svh"

module saw_cordic_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [saw_pkg::ANG_IDX_W-1:0]  stage_idx_i,
  input  logic                           valid_i,
  input  saw_pkg::lane_t                 lane_l_i,
  input  saw_pkg::lane_t                 lane_r_i,
  input  saw_pkg::side_t                 side_i,
  output logic                           valid_o,
  output saw_pkg::lane_t                 lane_l_o,
  output saw_pkg::lane_t                 lane_r_o,
  output saw_pkg::side_t                 side_o
);

  logic           valid_q;
  saw_pkg::lane_t lane_l_q, lane_r_q;
  saw_pkg::side_t side_q;

  // a lane whose y is already zero passes unchanged
  function automatic saw_pkg::lane_t rotate(input saw_pkg::lane_t a,
                                            input logic [saw_pkg::ANG_IDX_W-1:0] k);
    logic signed [saw_pkg::CW-1:0] cx;
    logic signed [saw_pkg::CW-1:0] cy;
    logic signed [saw_pkg::CW-1:0] xs;
    logic signed [saw_pkg::CW-1:0] ys;
    logic signed [saw_pkg::ZW-1:0] ang;
    saw_pkg::lane_t                b;
    cx  = a.cx;
    cy  = a.cy;
    xs  = cx >>> k;
    ys  = cy >>> k;
    ang = $signed({{(saw_pkg::ZW - saw_pkg::ANG_W){1'b0}}, saw_pkg::angle_of(k)});
    b   = a;
    if (cy[saw_pkg::CW-1]) begin
      b.cx = cx - ys;
      b.cy = cy + xs;
      b.z  = a.z - ang;
    end else if (cy != '0) begin
      b.cx = cx + ys;
      b.cy = cy - xs;
      b.z  = a.z + ang;
    end
    return b;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_l_q <= rotate(lane_l_i, stage_idx_i);
      lane_r_q <= rotate(lane_r_i, stage_idx_i);
      side_q   <= side_i;
    end
  end

  assign valid_o  = valid_q;
  assign lane_l_o = lane_l_q;
  assign lane_r_o = lane_r_q;
  assign side_o   = side_q;

  `SAW_ASSERT_NEXT(a_zero_y_stays_zero, en_i && valid_i && (lane_l_i.cy == '0), (lane_l_q.cy == '0) && (lane_l_q.z == $past(lane_l_i.z)))

endmodule

`default_nettype wire

>>> design/saw_mix.sv
// symmetry, bias, mid/side width and dry/wet mix stages
`timescale 1ns / 1ps
`default_nettype none

module saw_mix (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  saw_pkg::cfg_t                     cfg_i,
  input  logic                              valid_i,
  input  saw_pkg::lane_t                    lane_l_i,
  input  saw_pkg::lane_t                    lane_r_i,
  input  saw_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic signed [saw_pkg::ACC_W-1:0]  acc_l_o,
  output logic signed [saw_pkg::ACC_W-1:0]  acc_r_o,
  output logic                              last_o
);

  localparam int Pw1 = saw_pkg::ZW + 18;
  localparam int Pw2 = saw_pkg::SW + 17;
  localparam int Pw3 = saw_pkg::SW + 18;
  localparam int Pd  = saw_pkg::SAMPLE_W + 17;

  logic [saw_pkg::MIX_STAGES-1:0] v_q;
  saw_pkg::side_t                 side_q [saw_pkg::MIX_STAGES];

  logic signed [saw_pkg::ZW-1:0]    s_l_q, s_r_q;
  logic signed [saw_pkg::SW-1:0]    y_l_q, y_r_q;
  logic signed [saw_pkg::SW-1:0]    p_l_q, p_r_q;
  logic signed [saw_pkg::SW-1:0]    mid_q, sd_q;
  logic signed [saw_pkg::SW-1:0]    mid2_q, sw_q;
  logic signed [saw_pkg::SW:0]      wet_l_q, wet_r_q;
  logic signed [Pw3-1:0]            pw_l_q, pw_r_q;
  logic signed [Pd-1:0]             pd_l_q, pd_r_q;
  logic signed [saw_pkg::ACC_W-1:0] acc_l_q, acc_r_q;

  logic signed [17:0]               fac_l, fac_r;
  logic signed [Pw1-1:0]            prod_l, prod_r;
  logic signed [saw_pkg::SW-1:0]    bd_ext;
  logic signed [saw_pkg::SW:0]      sum, dif;
  logic signed [Pw2-1:0]            swp;
  logic signed [16:0]               width_s, wet_s, dry_s;

  // non-negative shaped values take 1+symmetry, negative ones 1-symmetry
  assign fac_l   = s_l_q[saw_pkg::ZW-1] ? $signed({2'b00, cfg_i.sym_neg}) :
                                          $signed({1'b0, cfg_i.sym_pos});
  assign fac_r   = s_r_q[saw_pkg::ZW-1] ? $signed({2'b00, cfg_i.sym_neg}) :
                                          $signed({1'b0, cfg_i.sym_pos});
  assign prod_l  = s_l_q * fac_l;
  assign prod_r  = s_r_q * fac_r;
  assign bd_ext  = saw_pkg::SW'(cfg_i.bias_dc) <<< saw_pkg::Q15_SH;
  assign sum     = (saw_pkg::SW + 1)'(p_l_q) + (saw_pkg::SW + 1)'(p_r_q);
  assign dif     = (saw_pkg::SW + 1)'(p_l_q) - (saw_pkg::SW + 1)'(p_r_q);
  assign width_s = $signed({1'b0, cfg_i.width});
  assign wet_s   = $signed({1'b0, cfg_i.wet});
  assign dry_s   = $signed({1'b0, cfg_i.dry});
  assign swp     = sd_q * width_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[saw_pkg::MIX_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < saw_pkg::MIX_STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
      // sign of the input restored
      s_l_q   <= lane_l_i.neg ? -lane_l_i.z : lane_l_i.z;
      s_r_q   <= lane_r_i.neg ? -lane_r_i.z : lane_r_i.z;
      y_l_q   <= saw_pkg::SW'(prod_l >>> saw_pkg::Q15_SH);
      y_r_q   <= saw_pkg::SW'(prod_r >>> saw_pkg::Q15_SH);
      p_l_q   <= y_l_q + bd_ext;
      p_r_q   <= y_r_q + bd_ext;
      mid_q   <= saw_pkg::SW'(sum >>> 1);
      sd_q    <= saw_pkg::SW'(dif >>> 1);
      mid2_q  <= mid_q;
      sw_q    <= saw_pkg::SW'(swp >>> saw_pkg::Q15_SH);
      wet_l_q <= (saw_pkg::SW + 1)'(mid2_q) + (saw_pkg::SW + 1)'(sw_q);
      wet_r_q <= (saw_pkg::SW + 1)'(mid2_q) - (saw_pkg::SW + 1)'(sw_q);
      pw_l_q  <= wet_l_q * wet_s;
      pw_r_q  <= wet_r_q * wet_s;
      pd_l_q  <= side_q[5].dry_l * dry_s;
      pd_r_q  <= side_q[5].dry_r * dry_s;
      // dry path lines up with the q.30 wet path plus 15 mix fraction bits
      acc_l_q <= saw_pkg::ACC_W'(pw_l_q) + (saw_pkg::ACC_W'(pd_l_q) <<< saw_pkg::DRY_SH);
      acc_r_q <= saw_pkg::ACC_W'(pw_r_q) + (saw_pkg::ACC_W'(pd_r_q) <<< saw_pkg::DRY_SH);
    end
  end

  assign valid_o = v_q[saw_pkg::MIX_STAGES-1];
  assign acc_l_o = acc_l_q;
  assign acc_r_o = acc_r_q;
  assign last_o  = side_q[saw_pkg::MIX_STAGES-1].last;

endmodule

`default_nettype wire

>>> design/stereo_atan_waveshaper_core.sv
// top level of the stereo arctangent soft-clip waveshaper
`timescale 1ns / 1ps
`default_nettype none

//  port        dir  payload                              transaction
//  in_frame    in   left_in, right_in, frame_last        valid && ready
//  out_frame   out  left_out, right_out, frame_last_out  valid && ready
//  cfg_*       in   cfg_idx_i, cfg_wdata_i               cfg_we_i high
//
//  one stereo frame per cycle unless held; front end, cordic row, mix tail, output reg
//  the cordic row sets the depth: one cell per atan iteration, both channels side by side
//  reset clears all valid bits and loads the register reset values
//  the whole pipe holds only when the output register is full, not taken, and
//  the last mix stage carries a frame; bubbles let it keep moving otherwise

`include "stereo_atan_waveshaper_core_macros.svh"

module stereo_atan_waveshaper_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  saw_in_if.sink                        in_frame,
  saw_out_if.source                     out_frame,
  input  logic                          cfg_we_i,
  input  logic [saw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [saw_pkg::FRAC_W-1:0]    cfg_wdata_i
);

  localparam int NStg = saw_pkg::NUM_STAGES;

  saw_pkg::cfg_t cfg;

  // pipeline advance, shared by the front end, every cordic cell and the mix tail
  logic en;
  logic stall;

  // cordic row, index 0 is fed by the front end
  logic [NStg:0]  chain_v;
  saw_pkg::lane_t chain_l    [NStg+1];
  saw_pkg::lane_t chain_r    [NStg+1];
  saw_pkg::side_t chain_side [NStg+1];

  // mix tail
  logic                             tail_valid;
  logic signed [saw_pkg::ACC_W-1:0] tail_acc_l, tail_acc_r;
  logic                             tail_last;

  // output register
  logic                                out_valid_q;
  logic signed [saw_pkg::SAMPLE_W-1:0] out_l_q, out_r_q;
  logic                                out_last_q;

  // round half up to the output fraction, then clip to the sample range
  function automatic logic signed [saw_pkg::SAMPLE_W-1:0] round_sat(
      input logic signed [saw_pkg::ACC_W-1:0] acc);
    logic signed [saw_pkg::ACC_W-1:0] r;
    r = (acc + saw_pkg::ROUND_HALF) >>> saw_pkg::ROUND_SH;
    if (r > saw_pkg::SAT_HI) begin
      return saw_pkg::SAT_HI[saw_pkg::SAMPLE_W-1:0];
    end else if (r < saw_pkg::SAT_LO) begin
      return saw_pkg::SAT_LO[saw_pkg::SAMPLE_W-1:0];
    end
    return r[saw_pkg::SAMPLE_W-1:0];
  endfunction

  saw_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // held output with a frame behind it freezes the pipe
  assign stall          = out_valid_q & ~out_frame.ready;
  assign en             = ~(stall & tail_valid);
  assign in_frame.ready = en;

  saw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_frame.valid),
    .left_i   (in_frame.left_in),
    .right_i  (in_frame.right_in),
    .last_i   (in_frame.frame_last),
    .gain_i   (cfg.gain),
    .valid_o  (chain_v[0]),
    .lane_l_o (chain_l[0]),
    .lane_r_o (chain_r[0]),
    .side_o   (chain_side[0])
  );

  for (genvar g = 0; g < NStg; g++) begin : g_cell
    saw_cordic_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .stage_idx_i (saw_pkg::ANG_IDX_W'(g)),
      .valid_i     (chain_v[g]),
      .lane_l_i    (chain_l[g]),
      .lane_r_i    (chain_r[g]),
      .side_i      (chain_side[g]),
      .valid_o     (chain_v[g+1]),
      .lane_l_o    (chain_l[g+1]),
      .lane_r_o    (chain_r[g+1]),
      .side_o      (chain_side[g+1])
    );
  end

  saw_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cfg_i    (cfg),
    .valid_i  (chain_v[NStg]),
    .lane_l_i (chain_l[NStg]),
    .lane_r_i (chain_r[NStg]),
    .side_i   (chain_side[NStg]),
    .valid_o  (tail_valid),
    .acc_l_o  (tail_acc_l),
    .acc_r_o  (tail_acc_r),
    .last_o   (tail_last)
  );

  // output register: refills whenever it is empty or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!stall) begin
      out_valid_q <= tail_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && tail_valid) begin
      out_l_q    <= round_sat(tail_acc_l);
      out_r_q    <= round_sat(tail_acc_r);
      out_last_q <= tail_last;
    end
  end

  assign out_frame.valid          = out_valid_q;
  assign out_frame.left_out       = out_l_q;
  assign out_frame.right_out      = out_r_q;
  assign out_frame.frame_last_out = out_last_q;

  // a free output register takes exactly what the tail held
  `SAW_ASSERT_NEXT(a_out_follows_tail, !out_valid_q || out_frame.ready, out_valid_q == $past(tail_valid))
  // a frame waiting at the tail is never dropped while the output holds
  `SAW_ASSERT_NEXT(a_tail_held_on_stall, out_valid_q && !out_frame.ready && tail_valid, tail_valid && out_valid_q)

endmodule

`default_nettype wire
